@@ src/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared constants and register codes for the DDA ray setup block.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int MAP_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_DIR_X  = 3'd2,
    REG_DIR_Y  = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } cfg_reg_t;

endpackage

@@ src/rsd_col_if.sv @@
// ----------------------------------------------------------------------------
// rsd_col_if
// Column channel: one camera-plane offset per transfer.
// ----------------------------------------------------------------------------
interface rsd_col_if #(
  parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] camera_offset;

  modport source (output valid, output camera_offset, input ready);
  modport sink   (input valid, input camera_offset, output ready);
endinterface

@@ src/rsd_ray_if.sv @@
// ----------------------------------------------------------------------------
// rsd_ray_if
// Ray channel: per-column ray direction, cell, steps and DDA distances.
// ----------------------------------------------------------------------------
interface rsd_ray_if #(
  parameter int MAP_BITS  = rsd_pkg::MAP_BITS_DEF,
  parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [FRAC_BITS+2:0]          ray_dir_x;
  logic signed [FRAC_BITS+2:0]          ray_dir_y;
  logic        [MAP_BITS-1:0]           cell_x;
  logic        [MAP_BITS-1:0]           cell_y;
  logic                                 step_x_negative;
  logic                                 step_y_negative;
  logic        [MAP_BITS+FRAC_BITS-1:0] delta_x;
  logic        [MAP_BITS+FRAC_BITS-1:0] delta_y;
  logic        [MAP_BITS+FRAC_BITS-1:0] side_x;
  logic        [MAP_BITS+FRAC_BITS-1:0] side_y;

  modport source (output valid, output ray_dir_x, output ray_dir_y, output cell_x,
                  output cell_y, output step_x_negative, output step_y_negative,
                  output delta_x, output delta_y, output side_x, output side_y,
                  input ready);
  modport sink   (input valid, input ray_dir_x, input ray_dir_y, input cell_x,
                  input cell_y, input step_x_negative, input step_y_negative,
                  input delta_x, input delta_y, input side_x, input side_y,
                  output ready);
endinterface

@@ src/rsd_axis.sv @@
// ----------------------------------------------------------------------------
// rsd_axis
// One axis of the ray setup: ray component, reciprocal by a pipelined
// restoring divider (one quotient bit per stage), and side distance.
// ----------------------------------------------------------------------------
module rsd_axis #(
  parameter int MAP_BITS  = rsd_pkg::MAP_BITS_DEF,
  parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [FRAC_BITS+1:0]          offset,
  input  logic signed [FRAC_BITS+1:0]          dir,
  input  logic signed [FRAC_BITS+1:0]          plane,
  input  logic        [MAP_BITS+FRAC_BITS-1:0] pos,
  output logic signed [FRAC_BITS+2:0]          ray,
  output logic                                 step_neg,
  output logic        [MAP_BITS+FRAC_BITS-1:0] delta,
  output logic        [MAP_BITS+FRAC_BITS-1:0] side
);

  localparam int F      = FRAC_BITS;
  localparam int DIR_W  = F + 2;
  localparam int RAY_W  = F + 3;
  localparam int MAG_W  = F + 3;
  localparam int QW     = MAP_BITS + F;
  localparam int PROD_W = 2 * DIR_W;
  localparam int SUM_W  = F + 6;
  localparam int DW     = MAG_W + QW + 1;
  localparam int SMUL_W = F + 1 + QW;

  localparam logic signed [PROD_W:0]  RND    = (PROD_W+1)'(1) <<< (F - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (RAY_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (RAY_W - 1));
  localparam logic [DW-1:0]           NUM    = DW'(1) << (2 * F);
  localparam logic [QW-1:0]           QMAX   = '1;

  // stage 1: product
  logic signed [PROD_W-1:0] prod;
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(plane) * PROD_W'(offset);
    end
  end

  // stage 2: round, add, saturate
  logic signed [PROD_W:0]   biased;
  logic signed [SUM_W-1:0]  rnd_s;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RAY_W-1:0]  ray2;
  assign biased = $signed({prod[PROD_W-1], prod}) + RND;
  assign rnd_s  = SUM_W'(biased >>> F);
  assign sum    = rnd_s + SUM_W'(dir);
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > SAT_HI) begin
        ray2 <= RAY_W'(SAT_HI);
      end else if (sum < SAT_LO) begin
        ray2 <= RAY_W'(SAT_LO);
      end else begin
        ray2 <= RAY_W'(sum);
      end
    end
  end

  // stage 3 (index 0) onward: divider pipeline with carried fields
  logic [DW-1:0]          rem    [0:QW-1];
  logic [QW-1:0]          quo    [0:QW];
  logic [MAG_W-1:0]       mag_p  [0:QW-1];
  logic signed [RAY_W-1:0] ray_p [0:QW];
  logic                   neg_p  [0:QW];
  logic                   zero_p [0:QW];
  logic                   ovf_p  [0:QW];
  logic [F:0]             dist_p [0:QW];

  logic             neg0;
  logic [MAG_W-1:0] mag0;
  logic [F-1:0]     frac;
  assign neg0 = ray2[RAY_W-1];
  assign mag0 = neg0 ? MAG_W'(~ray2 + RAY_W'(1)) : MAG_W'(ray2);
  assign frac = pos[F-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= NUM;
      quo[0]    <= '0;
      mag_p[0]  <= mag0;
      ray_p[0]  <= ray2;
      neg_p[0]  <= neg0;
      zero_p[0] <= (ray2 == '0);
      ovf_p[0]  <= ({{(DW-MAG_W-QW){1'b0}}, mag0, {QW{1'b0}}} <= NUM);
      dist_p[0] <= neg0 ? {1'b0, frac} : ((F+1)'(1) << F) - {1'b0, frac};
    end
  end

  genvar k;
  generate
    for (k = 1; k <= QW; k++) begin : g_div
      localparam int B = QW - k;
      logic [DW-1:0] sh;
      logic          ge;
      assign sh = {{(DW-MAG_W){1'b0}}, mag_p[k-1]} << B;
      assign ge = rem[k-1] >= sh;
      always_ff @(posedge clk) begin
        if (en) begin
          quo[k]    <= quo[k-1] | (QW'(ge) << B);
          ray_p[k]  <= ray_p[k-1];
          neg_p[k]  <= neg_p[k-1];
          zero_p[k] <= zero_p[k-1];
          ovf_p[k]  <= ovf_p[k-1];
          dist_p[k] <= dist_p[k-1];
        end
      end
      if (k < QW) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[k]   <= ge ? rem[k-1] - sh : rem[k-1];
            mag_p[k] <= mag_p[k-1];
          end
        end
      end
    end
  endgenerate

  // multiply stage: distance times delta
  logic [QW-1:0]         dsel;
  logic [SMUL_W-1:0]     smul;
  logic [QW-1:0]         delta_m;
  logic signed [RAY_W-1:0] ray_m;
  logic                  neg_m;
  logic                  zero_m;
  assign dsel = ovf_p[QW] ? QMAX : quo[QW];
  always_ff @(posedge clk) begin
    if (en) begin
      smul    <= SMUL_W'(dist_p[QW]) * SMUL_W'(dsel);
      delta_m <= dsel;
      ray_m   <= ray_p[QW];
      neg_m   <= neg_p[QW];
      zero_m  <= zero_p[QW];
    end
  end

  // output stage
  logic [QW:0] sh_side;
  assign sh_side = smul[F +: QW+1];
  always_ff @(posedge clk) begin
    if (en) begin
      ray      <= ray_m;
      step_neg <= neg_m;
      delta    <= delta_m;
      side     <= (zero_m || sh_side[QW]) ? QMAX : sh_side[QW-1:0];
    end
  end

endmodule

@@ src/ray_setup_dda.sv @@
// ----------------------------------------------------------------------------
// ray_setup_dda
// Per-column ray setup for a DDA grid walk: ray direction, player cell,
// step signs, reciprocal delta distances and initial side distances.
// ----------------------------------------------------------------------------
// Pipeline: product, rounding and saturation, divider, multiply and output
// stages; the divider resolves one quotient bit per stage.
// Throughput: one column per cycle unless stalled; an output skid register
// keeps the pipeline moving for one extra transfer when the ray side stalls.
// Reset: clears valid and skid state and loads the config reset values.
// ----------------------------------------------------------------------------
module ray_setup_dda #(
  parameter int MAP_BITS  = rsd_pkg::MAP_BITS_DEF,
  parameter int FRAC_BITS = rsd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [MAP_BITS+FRAC_BITS-1:0]       cfg_data,
  rsd_col_if.sink                             columns,
  rsd_ray_if.source                           rays
);

  localparam int F     = FRAC_BITS;
  localparam int DIR_W = F + 2;
  localparam int RAY_W = F + 3;
  localparam int POS_W = MAP_BITS + F;
  localparam int L     = POS_W + 5;

  localparam logic [DIR_W-1:0] DIR_X_RST   = DIR_W'(1) << F;
  localparam logic [DIR_W-1:0] PLANE_Y_RST = DIR_W'((64'd43254 << F) >> 16);
  localparam logic [POS_W-1:0] DIST_MAX    = '1;

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y, plane_x, plane_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      dir_x   <= DIR_X_RST;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= PLANE_Y_RST;
    end else if (cfg_we) begin
      case (rsd_pkg::cfg_reg_t'(cfg_index))
        rsd_pkg::REG_POS_X:   pos_x   <= cfg_data;
        rsd_pkg::REG_POS_Y:   pos_y   <= cfg_data;
        rsd_pkg::REG_DIR_X:   dir_x   <= cfg_data[DIR_W-1:0];
        rsd_pkg::REG_DIR_Y:   dir_y   <= cfg_data[DIR_W-1:0];
        rsd_pkg::REG_PLANE_X: plane_x <= cfg_data[DIR_W-1:0];
        rsd_pkg::REG_PLANE_Y: plane_y <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic         skid_v;
  logic         en;
  logic [L-1:0] vld;
  assign en            = !skid_v;
  assign columns.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], columns.valid};
    end
  end

  logic signed [RAY_W-1:0] ray_x, ray_y;
  logic                    neg_x, neg_y;
  logic [POS_W-1:0]        dlt_x, dlt_y, sd_x, sd_y;

  rsd_axis #(.MAP_BITS(MAP_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .en(en), .offset(columns.camera_offset), .dir(dir_x), .plane(plane_x),
    .pos(pos_x), .ray(ray_x), .step_neg(neg_x), .delta(dlt_x), .side(sd_x)
  );

  rsd_axis #(.MAP_BITS(MAP_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .en(en), .offset(columns.camera_offset), .dir(dir_y), .plane(plane_y),
    .pos(pos_y), .ray(ray_y), .step_neg(neg_y), .delta(dlt_y), .side(sd_y)
  );

  // skid register
  logic signed [RAY_W-1:0] sk_ray_x, sk_ray_y;
  logic                    sk_neg_x, sk_neg_y;
  logic [POS_W-1:0]        sk_dlt_x, sk_dlt_y, sk_sd_x, sk_sd_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (rays.ready) begin
        skid_v <= 1'b0;
      end
    end else if (vld[L-1] && !rays.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      sk_ray_x <= ray_x;
      sk_ray_y <= ray_y;
      sk_neg_x <= neg_x;
      sk_neg_y <= neg_y;
      sk_dlt_x <= dlt_x;
      sk_dlt_y <= dlt_y;
      sk_sd_x  <= sd_x;
      sk_sd_y  <= sd_y;
    end
  end

  assign rays.valid           = skid_v || vld[L-1];
  assign rays.ray_dir_x       = skid_v ? sk_ray_x : ray_x;
  assign rays.ray_dir_y       = skid_v ? sk_ray_y : ray_y;
  assign rays.step_x_negative = skid_v ? sk_neg_x : neg_x;
  assign rays.step_y_negative = skid_v ? sk_neg_y : neg_y;
  assign rays.delta_x         = skid_v ? sk_dlt_x : dlt_x;
  assign rays.delta_y         = skid_v ? sk_dlt_y : dlt_y;
  assign rays.side_x          = skid_v ? sk_sd_x : sd_x;
  assign rays.side_y          = skid_v ? sk_sd_y : sd_y;
  assign rays.cell_x          = pos_x[F +: MAP_BITS];
  assign rays.cell_y          = pos_y[F +: MAP_BITS];

  // pipeline frozen while the skid holds a transfer
  a_skid_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_v |=> $stable(vld))
    else $error("pipeline moved while skid full");

  a_step_x: assert property (@(posedge clk) disable iff (rst)
    rays.valid |-> rays.step_x_negative == rays.ray_dir_x[RAY_W-1])
    else $error("step x sign mismatch");

  a_step_y: assert property (@(posedge clk) disable iff (rst)
    rays.valid |-> rays.step_y_negative == rays.ray_dir_y[RAY_W-1])
    else $error("step y sign mismatch");

  a_zero_x: assert property (@(posedge clk) disable iff (rst)
    (rays.valid && rays.ray_dir_x == '0) |->
      (rays.delta_x == DIST_MAX && rays.side_x == DIST_MAX))
    else $error("zero x ray not saturated");

  a_zero_y: assert property (@(posedge clk) disable iff (rst)
    (rays.valid && rays.ray_dir_y == '0) |->
      (rays.delta_y == DIST_MAX && rays.side_y == DIST_MAX))
    else $error("zero y ray not saturated");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_setup_dda. A directed table walks reset state,
// offset and register extremes, rounding ties, zero and saturated rays and
// unused register indexes. Randomized phases follow under varying register
// settings and backpressure. Every ray transfer is compared field by field
// with an independent fixed-point model or, for typed rows, a hand-set ray.
// ----------------------------------------------------------------------------
module testbench;

  localparam int M = rsd_pkg::MAP_BITS_DEF;
  localparam int F = rsd_pkg::FRAC_BITS_DEF;
  localparam int IW = rsd_pkg::CFG_IDX_W;
  localparam int P = M + F;
  localparam int LATENCY = M + F + 5;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LONG_HOLD = 300;
  localparam int OFF_TOP = 1 << F;

  localparam logic [IW-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [IW-1:0] REG_UNUSED_7 = 3'd7;

  localparam logic signed [F+2:0] RAY_HI = {1'b0, {(F+2){1'b1}}};
  localparam logic signed [F+2:0] RAY_LO = {1'b1, {(F+2){1'b0}}};
  localparam logic signed [F+1:0] DIR_HI = {1'b0, {(F+1){1'b1}}};
  localparam logic signed [F+1:0] DIR_LO = {1'b1, {(F+1){1'b0}}};
  localparam logic [P-1:0]        DIST_TOP = '1;

  typedef enum logic {ROW_CFG, ROW_COL} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
  typedef enum int {STYLE_RANDOM, STYLE_MAX, STYLE_MIN} cfg_style_t;

  typedef struct packed {
    logic signed [F+2:0] ray_dir_x;
    logic signed [F+2:0] ray_dir_y;
    logic [M-1:0]        cell_x;
    logic [M-1:0]        cell_y;
    logic                step_x_negative;
    logic                step_y_negative;
    logic [P-1:0]        delta_x;
    logic [P-1:0]        delta_y;
    logic [P-1:0]        side_x;
    logic [P-1:0]        side_y;
  } ray_t;

  typedef struct packed {
    logic signed [F+1:0] offset;
    bit                  typed;
    ray_t                want;
  } column_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [IW-1:0]          index;
    int                     value;
    bit                     typed;
    ray_t                   want;
  } row_t;

  localparam int DIRECTED_ROWS = 32;
  row_t directed [DIRECTED_ROWS] = '{
    // reset registers: facing +x, plane along y, player at origin
    '{ROW_COL, '0, 0, 1'b1,
      '{19'sd65536, 19'sd0, 8'd0, 8'd0, 1'b0, 1'b0,
        24'd65536, DIST_TOP, 24'd65536, DIST_TOP}},
    '{ROW_COL, '0, 65536, 1'b0, '0},
    '{ROW_COL, '0, -65536, 1'b0, '0},
    '{ROW_COL, '0, 131071, 1'b0, '0},
    '{ROW_COL, '0, -131072, 1'b0, '0},
    // tiny ray: delta saturates, rounding ties on the plane product
    '{ROW_CFG, rsd_pkg::REG_POS_X, 32'hFFFFFF, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_POS_Y, 32'h008000, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_DIR_X, 1, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_PLANE_X, 1, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_DIR_Y, -1, 1'b0, '0},
    '{ROW_COL, '0, 32768, 1'b0, '0},
    '{ROW_COL, '0, -32768, 1'b0, '0},
    '{ROW_COL, '0, 32767, 1'b0, '0},
    '{ROW_COL, '0, -65536, 1'b0, '0},
    '{ROW_COL, '0, 0, 1'b0, '0},
    // largest vectors: ray saturates on both axes
    '{ROW_CFG, rsd_pkg::REG_DIR_X, 131071, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_DIR_Y, -131072, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_PLANE_X, 131071, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_PLANE_Y, -131072, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_POS_X, 0, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_POS_Y, 0, 1'b0, '0},
    '{ROW_COL, '0, 131071, 1'b1,
      '{RAY_HI, RAY_LO, 8'd0, 8'd0, 1'b0, 1'b1,
        24'd16384, 24'd16384, 24'd16384, 24'd0}},
    '{ROW_COL, '0, -131072, 1'b0, '0},
    '{ROW_COL, '0, 65536, 1'b0, '0},
    // writes beyond the last register change nothing
    '{ROW_CFG, REG_UNUSED_6, 0, 1'b0, '0},
    '{ROW_CFG, REG_UNUSED_7, 32'hFFFFFF, 1'b0, '0},
    '{ROW_COL, '0, 0, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_DIR_X, -131072, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_PLANE_X, -131072, 1'b0, '0},
    '{ROW_CFG, rsd_pkg::REG_POS_X, 32'h00FFFF, 1'b0, '0},
    '{ROW_COL, '0, -131072, 1'b0, '0},
    '{ROW_COL, '0, 1, 1'b0, '0}
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [P-1:0]  cfg_data = '0;

  rsd_col_if columns ();
  rsd_ray_if rays ();

  ray_setup_dda dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .columns   (columns),
    .rays      (rays)
  );

  always #5 clk = ~clk;

  // register copies used by the predictor
  logic [P-1:0]        player_x, player_y;
  logic signed [F+1:0] facing_x, facing_y, plane_x, plane_y;

  column_t    pending_columns [$];
  ray_t       expected_rays [$];
  int         mismatches = 0;
  int         rays_seen = 0;
  int         quiet_cycles = 0;
  int         ray_hold_req = 0;
  idle_mode_t src_mode = IDLE_NONE;
  idle_mode_t snk_mode = IDLE_NONE;

  function automatic longint ray_component(input logic signed [F+1:0] dir, pl, off);
    longint prod, r;
    prod = longint'(pl) * longint'(off);
    r = longint'(dir) + ((prod + (longint'(1) <<< (F - 1))) >>> F);
    if (r > longint'(RAY_HI)) r = longint'(RAY_HI);
    if (r < longint'(RAY_LO)) r = longint'(RAY_LO);
    return r;
  endfunction

  function automatic void dda_axis(input longint ray, input logic [P-1:0] pos,
                                   output logic neg, output logic [P-1:0] delta,
                                   output logic [P-1:0] side);
    longint mag, d, span, s;
    neg = (ray < 0);
    if (ray == 0) begin
      delta = DIST_TOP;
      side = DIST_TOP;
      return;
    end
    mag = (ray < 0) ? -ray : ray;
    d = (longint'(1) << (2 * F)) / mag;
    if (d > longint'(DIST_TOP)) d = longint'(DIST_TOP);
    span = (ray < 0) ? longint'(pos[F-1:0]) : (longint'(1) << F) - longint'(pos[F-1:0]);
    s = (span * d) >> F;
    if (s > longint'(DIST_TOP)) s = longint'(DIST_TOP);
    delta = d[P-1:0];
    side = s[P-1:0];
  endfunction

  function automatic ray_t trace_ray(input logic signed [F+1:0] off);
    ray_t   r;
    longint rx, ry;
    rx = ray_component(facing_x, plane_x, off);
    ry = ray_component(facing_y, plane_y, off);
    r.ray_dir_x = rx[F+2:0];
    r.ray_dir_y = ry[F+2:0];
    r.cell_x = player_x[P-1:F];
    r.cell_y = player_y[P-1:F];
    dda_axis(rx, player_x, r.step_x_negative, r.delta_x, r.side_x);
    dda_axis(ry, player_y, r.step_y_negative, r.delta_y, r.side_y);
    return r;
  endfunction

  function automatic int next_gap(input idle_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      IDLE_LIGHT: begin
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
      end
      IDLE_HEAVY: begin
        if (roll < 35) return 0;
        if (roll < 85) return $urandom_range(1, 5);
        return $urandom_range(10, 60);
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [F+1:0] pick_offset();
    logic signed [F+1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = (F+2)'(OFF_TOP);
      2: v = (F+2)'(-OFF_TOP);
      3, 4: v = (F+2)'($urandom);
      default: v = (F+2)'(int'($urandom_range(0, 2 * OFF_TOP)) - OFF_TOP);
    endcase
    return v;
  endfunction

  // direction or plane value; bits above the register width are noise
  function automatic logic [P-1:0] pick_vector(input cfg_style_t style);
    logic signed [F+1:0] v;
    logic [P-1:0]        d;
    case (style)
      STYLE_MAX: v = DIR_HI;
      STYLE_MIN: v = DIR_LO;
      default: begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = DIR_HI;
          2: v = DIR_LO;
          3: v = (F+2)'(int'($urandom_range(0, 6)) - 3);
          4: v = (F+2)'($urandom_range(0, 1) ? OFF_TOP : -OFF_TOP);
          default: v = (F+2)'($urandom);
        endcase
      end
    endcase
    d = P'($urandom);
    d[F+1:0] = v;
    return d;
  endfunction

  function automatic logic [P-1:0] pick_position(input cfg_style_t style);
    logic [P-1:0] p;
    p = P'($urandom);
    case (style)
      STYLE_MAX: p = DIST_TOP;
      STYLE_MIN: p = '0;
      default: begin
        case ($urandom_range(0, 5))
          0: p = '0;
          1: p = DIST_TOP;
          2: p[F-1:0] = '0;
          default: ;
        endcase
      end
    endcase
    return p;
  endfunction

  task automatic write_reg(input logic [IW-1:0] idx, input logic [P-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsd_pkg::REG_POS_X:   player_x = data;
      rsd_pkg::REG_POS_Y:   player_y = data;
      rsd_pkg::REG_DIR_X:   facing_x = data[F+1:0];
      rsd_pkg::REG_DIR_Y:   facing_y = data[F+1:0];
      rsd_pkg::REG_PLANE_X: plane_x = data[F+1:0];
      rsd_pkg::REG_PLANE_Y: plane_y = data[F+1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_column(input column_t c);
    int gap;
    gap = next_gap(src_mode);
    if (gap > 0) begin
      columns.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_columns.push_back(c);
    columns.valid <= 1'b1;
    columns.camera_offset <= c.offset;
    @(posedge clk);
    while (!columns.ready) @(posedge clk);
  endtask

  // stop offering columns and wait for every outstanding ray
  task automatic drain_rays();
    columns.valid <= 1'b0;
    @(posedge clk);
    while (pending_columns.size() != 0 || expected_rays.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ray %0d %s: expected %h, got %h", rays_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : ray_check
    ray_t    got, want;
    column_t c;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((rays.valid && rays.ready) || (columns.valid && columns.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (rays.valid && rays.ready) begin
        got = '{rays.ray_dir_x, rays.ray_dir_y, rays.cell_x, rays.cell_y,
                rays.step_x_negative, rays.step_y_negative,
                rays.delta_x, rays.delta_y, rays.side_x, rays.side_y};
        if (expected_rays.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ray %0d: transfer with nothing expected", rays_seen);
        end else begin
          want = expected_rays.pop_front();
          compare_field("ray_dir_x", 32'(want.ray_dir_x), 32'(got.ray_dir_x));
          compare_field("ray_dir_y", 32'(want.ray_dir_y), 32'(got.ray_dir_y));
          compare_field("cell_x", 32'(want.cell_x), 32'(got.cell_x));
          compare_field("cell_y", 32'(want.cell_y), 32'(got.cell_y));
          compare_field("step_x_negative", 32'(want.step_x_negative),
                        32'(got.step_x_negative));
          compare_field("step_y_negative", 32'(want.step_y_negative),
                        32'(got.step_y_negative));
          compare_field("delta_x", 32'(want.delta_x), 32'(got.delta_x));
          compare_field("delta_y", 32'(want.delta_y), 32'(got.delta_y));
          compare_field("side_x", 32'(want.side_x), 32'(got.side_x));
          compare_field("side_y", 32'(want.side_y), 32'(got.side_y));
        end
        rays_seen++;
      end
      if (columns.valid && columns.ready && pending_columns.size() != 0) begin
        c = pending_columns.pop_front();
        expected_rays.push_back(c.typed ? c.want : trace_ray(c.offset));
      end
    end
  end

  initial begin : ray_sink
    int stall;
    stall = 0;
    rays.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ray_hold_req > 0) begin
        stall = ray_hold_req;
        ray_hold_req = 0;
      end else if (stall == 0 && rays.valid && rays.ready) begin
        stall = next_gap(snk_mode);
      end
      if (stall > 0) begin
        rays.ready <= 1'b0;
        stall--;
      end else begin
        rays.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    column_t    c;
    cfg_style_t style;
    columns.valid <= 1'b0;
    columns.camera_offset <= '0;
    player_x = '0;
    player_y = '0;
    facing_x = (F+2)'(OFF_TOP);
    facing_y = '0;
    plane_x = '0;
    plane_y = (F+2)'((longint'(43254) << F) >> 16);
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_mode = IDLE_LIGHT;
    snk_mode = IDLE_LIGHT;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_rays();
        write_reg(directed[i].index, directed[i].value[P-1:0]);
      end else begin
        c.offset = directed[i].value[F+1:0];
        c.typed = directed[i].typed;
        c.want = directed[i].want;
        send_column(c);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_rays();
      style = (ph == PHASES - 2) ? STYLE_MAX : (ph == PHASES - 1) ? STYLE_MIN : STYLE_RANDOM;
      write_reg(rsd_pkg::REG_POS_X, pick_position(style));
      write_reg(rsd_pkg::REG_POS_Y, pick_position(style));
      write_reg(rsd_pkg::REG_DIR_X, pick_vector(style));
      write_reg(rsd_pkg::REG_DIR_Y, pick_vector(style));
      write_reg(rsd_pkg::REG_PLANE_X, pick_vector(style));
      write_reg(rsd_pkg::REG_PLANE_Y, pick_vector(style));
      write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, P'($urandom));
      src_mode = (ph % 3 == 0) ? IDLE_NONE : (ph % 3 == 1) ? IDLE_LIGHT : IDLE_HEAVY;
      snk_mode = (ph % 4 == 1) ? IDLE_HEAVY : (ph % 4 == 2) ? IDLE_NONE : IDLE_LIGHT;
      if (ph == 2) begin
        // sink holds off while columns keep coming
        src_mode = IDLE_NONE;
        ray_hold_req = LONG_HOLD;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) drain_rays();
        c.offset = pick_offset();
        c.typed = 1'b0;
        c.want = '0;
        send_column(c);
      end
    end

    drain_rays();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
src/rsd_pkg.sv
src/rsd_col_if.sv
src/rsd_ray_if.sv
src/rsd_axis.sv
src/ray_setup_dda.sv
tb/testbench.sv
